### rtl/pwft_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwft_pkg
// Types and constants shared by the wire field tokenizer modules.
// ----------------------------------------------------------------------------
package pwft_pkg;

  localparam int unsigned OFFSET_BITS_DEF = 16;
  localparam int unsigned OFFSET_OUT_W    = 16;
  localparam int unsigned FN_W            = 29;
  localparam int unsigned LEN_W           = 35;
  localparam int unsigned VAL_W           = 64;
  localparam int unsigned CNT_W           = 4;

  localparam logic [7:0]       LOW7_MASK       = 8'h7F;
  localparam int unsigned      CONT_BIT        = 7;
  localparam logic [CNT_W-1:0] MAX_VALUE_BYTES = 4'd10;
  localparam logic [CNT_W-1:0] MAX_SHORT_BYTES = 4'd5;
  localparam logic [LEN_W-1:0] FIXED64_LEN     = 35'd8;
  localparam logic [LEN_W-1:0] FIXED32_LEN     = 35'd4;

  localparam logic [2:0] WT_VARINT  = 3'd0;
  localparam logic [2:0] WT_FIXED64 = 3'd1;
  localparam logic [2:0] WT_LEN     = 3'd2;
  localparam logic [2:0] WT_SGROUP  = 3'd3;
  localparam logic [2:0] WT_EGROUP  = 3'd4;
  localparam logic [2:0] WT_FIXED32 = 3'd5;

  typedef enum logic [2:0] {
    PH_TAG,
    PH_VARINT,
    PH_FIXED,
    PH_LENPFX,
    PH_PAYLOAD,
    PH_POISON
  } phase_e;

  typedef enum logic [1:0] {
    KIND_FIELD,
    KIND_ERROR,
    KIND_POISON_END
  } kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic     valid;
    in_item_t item;
  } stage_t;

  typedef struct packed {
    kind_e                   record_kind;
    logic [FN_W-1:0]         field_number;
    logic [2:0]              wire_type;
    logic [OFFSET_OUT_W-1:0] value_offset;
    logic [LEN_W-1:0]        value_length;
    logic [VAL_W-1:0]        varint_value;
    logic                    last_record;
  } rec_t;

endpackage

### rtl/pwft_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwft_byte_if / pwft_rec_if
// Request channels for message bytes and decoded field records.
// ----------------------------------------------------------------------------
interface pwft_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface pwft_rec_if;
  logic        valid;
  logic        ready;
  logic [1:0]  record_kind;
  logic [28:0] field_number;
  logic [2:0]  wire_type;
  logic [15:0] value_offset;
  logic [34:0] value_length;
  logic [63:0] varint_value;
  logic        last_record;

  modport source (output valid, output record_kind, output field_number,
                  output wire_type, output value_offset, output value_length,
                  output varint_value, output last_record, input ready);
  modport sink   (input valid, input record_kind, input field_number,
                  input wire_type, input value_offset, input value_length,
                  input varint_value, input last_record, output ready);
endinterface

### rtl/pwft_in_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwft_in_reg
// Input register: holds one accepted byte until the parser takes it.
// ----------------------------------------------------------------------------
module pwft_in_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  pwft_pkg::in_item_t item_i,
  output logic              ready_o,
  input  logic              take_i,
  output pwft_pkg::stage_t  stage_o
);
  import pwft_pkg::*;

  logic     valid_q, valid_d;
  in_item_t item_q;

  assign ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.item  = item_q;

endmodule

### rtl/pwft_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwft_parser
// Parse state and one-byte update; builds the record a byte completes.
// ----------------------------------------------------------------------------
module pwft_parser #(
  parameter int unsigned OFFSET_BITS = pwft_pkg::OFFSET_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  pwft_pkg::in_item_t item_i,
  output logic               emit_o,
  output pwft_pkg::rec_t     rec_o
);
  import pwft_pkg::*;

  phase_e                 phase_q, phase_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [VAL_W-1:0]       acc_q, acc_d;
  logic [FN_W-1:0]        fn_q, fn_d;
  logic [2:0]             wt_q, wt_d;
  logic [LEN_W-1:0]       rem_q, rem_d;
  logic [OFFSET_BITS-1:0] off_q, off_d;
  logic [OFFSET_BITS-1:0] vs_q, vs_d;

  logic [OFFSET_BITS-1:0] nxt;
  logic [6:0]             shamt;
  logic [VAL_W-1:0]       acc_new;
  logic [CNT_W-1:0]       cnt_new;
  logic [LEN_W-1:0]       rem_dec;
  logic [FN_W-1:0]        tag_fn;
  logic [2:0]             tag_wt;
  logic                   cont;
  logic                   last;

  phase_e                 phase_n;
  logic [CNT_W-1:0]       cnt_n;
  logic [VAL_W-1:0]       acc_n;
  logic [FN_W-1:0]        fn_n;
  logic [2:0]             wt_n;
  logic [LEN_W-1:0]       rem_n;
  logic [OFFSET_BITS-1:0] vs_n;
  logic                   fld, err, pend;
  logic [LEN_W-1:0]       fld_len;
  logic [VAL_W-1:0]       fld_val;

  assign nxt     = off_q + 1'b1;
  assign shamt   = 7'(cnt_q) * 7'd7;
  assign acc_new = acc_q | (VAL_W'(item_i.data_byte & LOW7_MASK) << shamt);
  assign cnt_new = cnt_q + 1'b1;
  assign rem_dec = rem_q - 1'b1;
  assign tag_fn  = acc_new[FN_W+2:3];
  assign tag_wt  = acc_new[2:0];
  assign cont    = item_i.data_byte[CONT_BIT];
  assign last    = item_i.last_byte;

  // byte update
  always_comb begin
    phase_n = phase_q;
    cnt_n   = cnt_q;
    acc_n   = acc_q;
    fn_n    = fn_q;
    wt_n    = wt_q;
    rem_n   = rem_q;
    vs_n    = vs_q;
    fld     = 1'b0;
    err     = 1'b0;
    pend    = 1'b0;
    fld_len = '0;
    fld_val = '0;
    case (phase_q)
      PH_TAG, PH_LENPFX: begin
        acc_n = acc_new;
        cnt_n = cnt_new;
        if (cont) begin
          if (cnt_new >= MAX_SHORT_BYTES) begin
            if (phase_q == PH_TAG) begin
              fn_n = '0;
              wt_n = '0;
            end
            err = 1'b1;
          end else if (last) begin
            err = 1'b1;
          end
        end else if (phase_q == PH_LENPFX) begin
          cnt_n = '0;
          acc_n = VAL_W'(acc_new[LEN_W-1:0]);
          vs_n  = nxt;
          if (acc_new[LEN_W-1:0] == '0) begin
            fld = 1'b1;
          end else if (last) begin
            err = 1'b1;
          end else begin
            rem_n   = acc_new[LEN_W-1:0];
            phase_n = PH_PAYLOAD;
          end
        end else begin
          fn_n  = tag_fn;
          wt_n  = tag_wt;
          cnt_n = '0;
          acc_n = '0;
          vs_n  = nxt;
          if (tag_fn == '0 || tag_wt > WT_FIXED32) begin
            err = 1'b1;
          end else if (tag_wt == WT_SGROUP || tag_wt == WT_EGROUP) begin
            fld = 1'b1;
          end else if (last) begin
            err = 1'b1;
          end else begin
            case (tag_wt)
              WT_VARINT: phase_n = PH_VARINT;
              WT_LEN:    phase_n = PH_LENPFX;
              WT_FIXED64: begin
                rem_n   = FIXED64_LEN;
                phase_n = PH_FIXED;
              end
              default: begin
                rem_n   = FIXED32_LEN;
                phase_n = PH_FIXED;
              end
            endcase
          end
        end
      end
      PH_VARINT: begin
        acc_n = acc_new;
        cnt_n = cnt_new;
        if (cont) begin
          if (cnt_new >= MAX_VALUE_BYTES || last) begin
            err = 1'b1;
          end
        end else begin
          fld     = 1'b1;
          fld_len = LEN_W'(cnt_new);
          fld_val = acc_new;
        end
      end
      PH_FIXED: begin
        rem_n = rem_dec;
        if (rem_dec == '0) begin
          fld     = 1'b1;
          fld_len = (wt_q == WT_FIXED64) ? FIXED64_LEN : FIXED32_LEN;
        end else if (last) begin
          err = 1'b1;
        end
      end
      PH_PAYLOAD: begin
        rem_n = rem_dec;
        if (rem_dec == '0) begin
          fld     = 1'b1;
          fld_len = acc_q[LEN_W-1:0];
        end else if (last) begin
          err = 1'b1;
        end
      end
      default: begin
        pend = last;
      end
    endcase
    if (fld) begin
      phase_n = PH_TAG;
      cnt_n   = '0;
      acc_n   = '0;
      rem_n   = '0;
    end
    if (err) begin
      phase_n = PH_POISON;
    end
  end

  // record for the current byte
  always_comb begin
    rec_o  = '0;
    emit_o = step_i && (fld || err || pend);
    if (fld) begin
      rec_o.record_kind  = KIND_FIELD;
      rec_o.field_number = fn_n;
      rec_o.wire_type    = wt_n;
      rec_o.value_offset = OFFSET_OUT_W'(vs_n);
      rec_o.value_length = fld_len;
      rec_o.varint_value = fld_val;
      rec_o.last_record  = last;
    end else if (err) begin
      rec_o.record_kind  = KIND_ERROR;
      rec_o.field_number = fn_n;
      rec_o.wire_type    = wt_n;
      rec_o.value_offset = OFFSET_OUT_W'(off_q);
      rec_o.last_record  = last;
    end else if (pend) begin
      rec_o.record_kind  = KIND_POISON_END;
      rec_o.last_record  = 1'b1;
    end
  end

  // commit, back to reset state after the final byte
  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    fn_d    = fn_q;
    wt_d    = wt_q;
    rem_d   = rem_q;
    off_d   = off_q;
    vs_d    = vs_q;
    if (step_i) begin
      if (last) begin
        phase_d = PH_TAG;
        cnt_d   = '0;
        acc_d   = '0;
        fn_d    = '0;
        wt_d    = '0;
        rem_d   = '0;
        off_d   = '0;
        vs_d    = '0;
      end else begin
        phase_d = phase_n;
        cnt_d   = cnt_n;
        acc_d   = acc_n;
        fn_d    = fn_n;
        wt_d    = wt_n;
        rem_d   = rem_n;
        off_d   = nxt;
        vs_d    = vs_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TAG;
      cnt_q   <= '0;
      acc_q   <= '0;
      fn_q    <= '0;
      wt_q    <= '0;
      rem_q   <= '0;
      off_q   <= '0;
      vs_q    <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      acc_q   <= acc_d;
      fn_q    <= fn_d;
      wt_q    <= wt_d;
      rem_q   <= rem_d;
      off_q   <= off_d;
      vs_q    <= vs_d;
    end
  end

endmodule

### rtl/pwft_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwft_out_reg
// Result register: holds one record until the sink takes it.
// ----------------------------------------------------------------------------
module pwft_out_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  logic           step_i,
  input  pwft_pkg::rec_t rec_i,
  input  logic           ready_i,
  output logic           free_o,
  output logic           valid_o,
  output pwft_pkg::rec_t rec_o
);
  import pwft_pkg::*;

  logic valid_q, valid_d;
  rec_t rec_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign rec_o   = rec_q;

  always_comb begin
    valid_d = valid_q;
    if (step_i) begin
      valid_d = load_i;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rec_q <= rec_i;
    end
  end

endmodule

### rtl/protobuf_wire_field_tokenizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// protobuf_wire_field_tokenizer
// Splits a protobuf wire-format byte stream into field, error and poisoned-end records.
//
//   channel  dir  request                         fires when
//   in_i     in   data_byte, last_byte            valid && ready
//   rec_o    out  record_kind .. last_record      valid && ready
//
// One byte per cycle while the result register is free; each byte passes
// the input register, the parse update and the result register.
// Reset clears parse state and both valid flags.
// A stalled result holds; the input register still takes one more byte.
// ----------------------------------------------------------------------------
module protobuf_wire_field_tokenizer #(
  parameter int unsigned OFFSET_BITS = pwft_pkg::OFFSET_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  pwft_byte_if.sink          in_i,
  pwft_rec_if.source         rec_o
);
  import pwft_pkg::*;

  in_item_t in_item;
  stage_t   stage;
  rec_t     rec_n, rec_q;
  logic     emit, step, free, in_ready;

  assign in_item.data_byte = in_i.data_byte;
  assign in_item.last_byte = in_i.last_byte;
  assign in_i.ready        = in_ready;

  assign step = stage.valid && free;

  pwft_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .item_i  (in_item),
    .ready_o (in_ready),
    .take_i  (step),
    .stage_o (stage)
  );

  pwft_parser #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (stage.item),
    .emit_o (emit),
    .rec_o  (rec_n)
  );

  pwft_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (emit),
    .step_i  (step),
    .rec_i   (rec_n),
    .ready_i (rec_o.ready),
    .free_o  (free),
    .valid_o (rec_o.valid),
    .rec_o   (rec_q)
  );

  assign rec_o.record_kind  = rec_q.record_kind;
  assign rec_o.field_number = rec_q.field_number;
  assign rec_o.wire_type    = rec_q.wire_type;
  assign rec_o.value_offset = rec_q.value_offset;
  assign rec_o.value_length = rec_q.value_length;
  assign rec_o.varint_value = rec_q.varint_value;
  assign rec_o.last_record  = rec_q.last_record;

endmodule

### rtl/pwft_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwft_checker
// Port-level checks on the record channel of the tokenizer.
// ----------------------------------------------------------------------------
module pwft_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        valid_i,
  input logic        ready_i,
  input logic [1:0]  record_kind_i,
  input logic [28:0] field_number_i,
  input logic [2:0]  wire_type_i,
  input logic [15:0] value_offset_i,
  input logic [34:0] value_length_i,
  input logic [63:0] varint_value_i,
  input logic        last_record_i
);
  import pwft_pkg::*;

  logic field_rec, error_rec, end_rec;

  assign field_rec = valid_i && record_kind_i == KIND_FIELD;
  assign error_rec = valid_i && record_kind_i == KIND_ERROR;
  assign end_rec   = valid_i && record_kind_i == KIND_POISON_END;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i && $stable(varint_value_i)
      && $stable(record_kind_i) && $stable(value_offset_i))
    else $error("record dropped or changed while stalled");

  a_end_rec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    end_rec |-> last_record_i && field_number_i == '0 && wire_type_i == '0
      && value_offset_i == '0 && value_length_i == '0)
    else $error("poisoned end record not empty");

  a_err_rec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    error_rec |-> value_length_i == '0 && varint_value_i == '0)
    else $error("error record carries a value");

  a_field_rec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    field_rec |-> field_number_i != '0 && wire_type_i <= WT_FIXED32
      && (wire_type_i == WT_VARINT || varint_value_i == '0))
    else $error("field record with bad tag or stray value");

endmodule

bind protobuf_wire_field_tokenizer pwft_checker u_pwft_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .valid_i        (rec_o.valid),
  .ready_i        (rec_o.ready),
  .record_kind_i  (rec_o.record_kind),
  .field_number_i (rec_o.field_number),
  .wire_type_i    (rec_o.wire_type),
  .value_offset_i (rec_o.value_offset),
  .value_length_i (rec_o.value_length),
  .varint_value_i (rec_o.varint_value),
  .last_record_i  (rec_o.last_record)
);

### tb/tb_protobuf_wire_field_tokenizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_protobuf_wire_field_tokenizer
// Feeds whole wire-format messages byte by byte, one request per byte, and
// checks each record against a cycle-free tokenizer kept in step with
// every accepted byte. Directed messages cover every wire type, the field
// and varint extremes, overlong varints, bad tags, truncation and poisoning.
// Random messages follow, mostly well formed with some cut, corrupted or
// pure noise. Both channels idle in random bursts.
// ----------------------------------------------------------------------------
module tb_protobuf_wire_field_tokenizer;
  import pwft_pkg::*;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  pwft_byte_if in_if ();
  pwft_rec_if  rec_if ();

  protobuf_wire_field_tokenizer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .rec_o  (rec_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  in_item_t    byte_q[$];
  rec_t        record_q[$];
  logic [7:0]  msg_bytes[$];
  int          fail_cnt   = 0;
  int unsigned gap_left   = 0;
  int unsigned stall_left = 0;
  logic        byte_taken = 1'b0;

  // tokenizer state
  phase_e      ph;
  logic [3:0]  vcnt;
  logic [63:0] acc;
  logic [28:0] cur_fn;
  logic [2:0]  cur_wt;
  logic [34:0] remain;
  logic [15:0] off;
  logic [15:0] vstart;

  function automatic void clear_parse();
    ph     = PH_TAG;
    vcnt   = '0;
    acc    = '0;
    cur_fn = '0;
    cur_wt = '0;
    remain = '0;
    off    = '0;
    vstart = '0;
  endfunction

  function automatic rec_t make_rec(kind_e kind, logic [28:0] fn, logic [2:0] wt,
                                    logic [15:0] offs, logic [34:0] len,
                                    logic [63:0] val, logic last);
    rec_t r;
    r.record_kind  = kind;
    r.field_number = fn;
    r.wire_type    = wt;
    r.value_offset = offs;
    r.value_length = len;
    r.varint_value = val;
    r.last_record  = last;
    return r;
  endfunction

  function automatic rec_t close_field(logic [34:0] len, logic [63:0] val, logic last);
    rec_t r;
    r      = make_rec(KIND_FIELD, cur_fn, cur_wt, vstart, len, val, last);
    vcnt   = '0;
    acc    = '0;
    remain = '0;
    ph     = PH_TAG;
    if (last) clear_parse();
    return r;
  endfunction

  function automatic rec_t poison_at(logic [15:0] pos, logic last);
    rec_t r;
    r = make_rec(KIND_ERROR, cur_fn, cur_wt, pos, '0, '0, last);
    if (last) clear_parse();
    else ph = PH_POISON;
    return r;
  endfunction

  function automatic bit tokenize_byte(logic [7:0] b, logic last, output rec_t rec);
    logic [15:0] pos;
    logic [15:0] nxt;
    logic [34:0] len;
    pos = off;
    nxt = off + 16'd1;
    off = nxt;
    rec = '0;
    case (ph)
      PH_TAG, PH_LENPFX: begin
        acc  = acc | (64'(b[6:0]) << (7 * vcnt));
        vcnt = vcnt + 4'd1;
        if (b[CONT_BIT]) begin
          if (vcnt >= MAX_SHORT_BYTES) begin
            if (ph == PH_TAG) begin
              cur_fn = '0;
              cur_wt = '0;
            end
            rec = poison_at(pos, last);
            return 1'b1;
          end
          if (last) begin
            rec = poison_at(pos, last);
            return 1'b1;
          end
          return 1'b0;
        end
        if (ph == PH_LENPFX) begin
          len    = acc[34:0];
          vcnt   = '0;
          acc    = 64'(len);
          vstart = nxt;
          if (len == '0) begin
            rec = close_field('0, '0, last);
            return 1'b1;
          end
          if (last) begin
            rec = poison_at(pos, last);
            return 1'b1;
          end
          remain = len;
          ph     = PH_PAYLOAD;
          return 1'b0;
        end
        cur_fn = acc[31:3];
        cur_wt = acc[2:0];
        vcnt   = '0;
        acc    = '0;
        vstart = nxt;
        if (cur_fn == '0 || cur_wt > WT_FIXED32) begin
          rec = poison_at(pos, last);
          return 1'b1;
        end
        if (cur_wt == WT_SGROUP || cur_wt == WT_EGROUP) begin
          rec = close_field('0, '0, last);
          return 1'b1;
        end
        if (last) begin
          rec = poison_at(pos, last);
          return 1'b1;
        end
        if (cur_wt == WT_VARINT) ph = PH_VARINT;
        else if (cur_wt == WT_LEN) ph = PH_LENPFX;
        else begin
          remain = (cur_wt == WT_FIXED64) ? FIXED64_LEN : FIXED32_LEN;
          ph     = PH_FIXED;
        end
        return 1'b0;
      end
      PH_VARINT: begin
        acc  = acc | (64'(b[6:0]) << (7 * vcnt));
        vcnt = vcnt + 4'd1;
        if (b[CONT_BIT]) begin
          if (vcnt >= MAX_VALUE_BYTES || last) begin
            rec = poison_at(pos, last);
            return 1'b1;
          end
          return 1'b0;
        end
        rec = close_field(35'(vcnt), acc, last);
        return 1'b1;
      end
      PH_FIXED: begin
        remain = remain - 35'd1;
        if (remain == '0) begin
          rec = close_field((cur_wt == WT_FIXED64) ? FIXED64_LEN : FIXED32_LEN, '0, last);
          return 1'b1;
        end
        if (last) begin
          rec = poison_at(pos, last);
          return 1'b1;
        end
        return 1'b0;
      end
      PH_PAYLOAD: begin
        remain = remain - 35'd1;
        if (remain == '0) begin
          rec = close_field(acc[34:0], '0, last);
          return 1'b1;
        end
        if (last) begin
          rec = poison_at(pos, last);
          return 1'b1;
        end
        return 1'b0;
      end
      default: begin
        if (last) begin
          rec = make_rec(KIND_POISON_END, '0, '0, '0, '0, '0, 1'b1);
          clear_parse();
          return 1'b1;
        end
        return 1'b0;
      end
    endcase
  endfunction

  // message building
  function automatic int unsigned varint_len(logic [63:0] v);
    int unsigned n;
    n = 1;
    while (v > 64'h7F) begin
      v = v >> 7;
      n++;
    end
    return n;
  endfunction

  function automatic void put_varint(logic [63:0] v, int unsigned pad);
    logic [63:0] r;
    r = v;
    msg_bytes.push_back({(r > 64'h7F) || (pad != 0), r[6:0]});
    r = r >> 7;
    while (r != '0) begin
      msg_bytes.push_back({(r > 64'h7F) || (pad != 0), r[6:0]});
      r = r >> 7;
    end
    for (int i = pad; i > 0; i--) msg_bytes.push_back({i > 1, 7'h00});
  endfunction

  function automatic void add_tag(logic [28:0] fn, logic [2:0] wt, int unsigned pad);
    put_varint(64'({fn, wt}), pad);
  endfunction

  function automatic void put_raw(logic [7:0] b, int unsigned n);
    repeat (n) msg_bytes.push_back(b);
  endfunction

  function automatic void put_noise(int unsigned n);
    repeat (n) msg_bytes.push_back(8'($urandom));
  endfunction

  function automatic int unsigned rare_pad(int unsigned room);
    return ($urandom_range(0, 7) == 0) ? $urandom_range(0, room) : 0;
  endfunction

  function automatic void add_random_field();
    logic [28:0] fn;
    logic [2:0]  wt;
    logic [63:0] v;
    int unsigned n;
    case ($urandom_range(0, 3))
      0: fn = 29'($urandom_range(1, 15));
      1: fn = 29'($urandom_range(16, 2047));
      2: fn = 29'($urandom) | 29'h1;
      default: fn = '1;
    endcase
    if ($urandom_range(0, 39) == 0) fn = '0;
    wt = ($urandom_range(0, 29) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
    add_tag(fn, wt, rare_pad(5 - varint_len(64'({fn, wt}))));
    case (wt)
      WT_VARINT: begin
        v = {$urandom, $urandom} >> $urandom_range(0, 63);
        put_varint(v, rare_pad(10 - varint_len(v)));
      end
      WT_FIXED64: put_noise(8);
      WT_FIXED32: put_noise(4);
      WT_LEN: begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 40) : $urandom_range(0, 5);
        put_varint(64'(n), rare_pad(4));
        put_noise(n);
      end
      default: ;
    endcase
  endfunction

  function automatic void send_msg();
    in_item_t it;
    if (msg_bytes.size() == 0) put_noise(1);
    for (int i = 0; i < msg_bytes.size(); i++) begin
      it.data_byte = msg_bytes[i];
      it.last_byte = (i == msg_bytes.size() - 1);
      byte_q.push_back(it);
    end
    msg_bytes.delete();
  endfunction

  task automatic check_field(string name, logic [63:0] want_v, logic [63:0] got_v);
    if (got_v !== want_v) begin
      fail_cnt++;
      if (fail_cnt <= 100)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
    end
  endtask

  // predict on accepted bytes, check accepted records
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    rec_t pred;
    rec_t want;
    if (!rst_ni) begin
      byte_taken <= 1'b0;
    end else begin
      byte_taken <= in_if.valid && in_if.ready;
      if (in_if.valid && in_if.ready) begin
        if (tokenize_byte(in_if.data_byte, in_if.last_byte, pred)) record_q.push_back(pred);
      end
      if (rec_if.valid && rec_if.ready) begin
        if (record_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 100)
            $display("%0t: unexpected request, expected none, actual kind %0d field %0d",
                     $time, rec_if.record_kind, rec_if.field_number);
        end else begin
          want = record_q.pop_front();
          check_field("record_kind", 64'(want.record_kind), 64'(rec_if.record_kind));
          check_field("field_number", 64'(want.field_number), 64'(rec_if.field_number));
          check_field("wire_type", 64'(want.wire_type), 64'(rec_if.wire_type));
          check_field("value_offset", 64'(want.value_offset), 64'(rec_if.value_offset));
          check_field("value_length", 64'(want.value_length), 64'(rec_if.value_length));
          check_field("varint_value", want.varint_value, rec_if.varint_value);
          check_field("last_record", 64'(want.last_record), 64'(rec_if.last_record));
        end
      end
    end
  end

  always @(negedge clk_i) begin : driver
    logic drive;
    logic rdy;
    logic calm;
    if (!rst_ni) begin
      in_if.valid   <= 1'b0;
      rec_if.ready  <= 1'b0;
    end else begin
      if (byte_taken) void'(byte_q.pop_front());
      calm = byte_q.size() < 80;
      if (in_if.valid && !byte_taken) begin
        drive = 1'b1;
      end else if (gap_left != 0) begin
        gap_left--;
        drive = 1'b0;
      end else if (byte_q.size() == 0) begin
        drive = 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        gap_left = $urandom_range(0, 9);
        drive    = 1'b0;
      end else begin
        drive = 1'b1;
      end
      in_if.valid <= drive;
      if (drive) begin
        in_if.data_byte <= byte_q[0].data_byte;
        in_if.last_byte <= byte_q[0].last_byte;
      end
      if (stall_left != 0) begin
        stall_left--;
        rdy = 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 9);
        rdy        = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      rec_if.ready <= rdy;
    end
  end

  initial begin : stimulus
    int unsigned rand_bytes;
    int unsigned sel;
    int unsigned keep;
    in_if.valid     = 1'b0;
    in_if.data_byte = '0;
    in_if.last_byte = 1'b0;
    rec_if.ready    = 1'b0;
    clear_parse();

    // every wire type, field and value extremes
    add_tag(29'd1, WT_VARINT, 0);
    put_varint(64'd0, 0);
    add_tag(29'd2, WT_FIXED64, 0);
    put_raw(8'hFF, 8);
    add_tag(29'd3, WT_FIXED32, 0);
    put_raw(8'h00, 4);
    add_tag(29'd4, WT_LEN, 0);
    put_varint(64'd3, 0);
    put_noise(3);
    add_tag(29'd5, WT_SGROUP, 0);
    add_tag(29'd5, WT_EGROUP, 0);
    add_tag('1, WT_VARINT, 0);
    put_varint('1, 0);
    send_msg();

    // dropped high tag bits, dropped varint bits, zero-length payload last
    msg_bytes = '{8'hF8, 8'hFF, 8'hFF, 8'hFF, 8'h7F};
    put_raw(8'hFF, 9);
    put_raw(8'h7F, 1);
    add_tag(29'd7, WT_LEN, 0);
    put_varint(64'd0, 0);
    send_msg();

    // padded varints at their limits, group tag last
    add_tag(29'd1, WT_VARINT, 4);
    put_varint(64'd1, 9);
    add_tag(29'd2, WT_LEN, 0);
    put_varint(64'd1, 4);
    put_raw(8'hAA, 1);
    add_tag(29'd9, WT_SGROUP, 0);
    send_msg();

    // field number zero or bad wire type, then poisoned bytes
    put_raw(8'h02, 1);
    put_noise(3);
    send_msg();
    add_tag(29'd1, 3'd6, 0);
    send_msg();
    add_tag(29'd3, 3'd7, 0);
    put_raw(8'h00, 1);
    send_msg();

    // overlong tag, value and length
    put_raw(8'h80, 5);
    put_raw(8'h00, 1);
    send_msg();
    add_tag(29'd1, WT_VARINT, 0);
    put_raw(8'h80, 10);
    put_raw(8'h01, 1);
    send_msg();
    add_tag(29'd1, WT_LEN, 0);
    put_raw(8'hFF, 5);
    put_raw(8'h01, 1);
    send_msg();

    // truncation in every phase
    put_raw(8'h88, 1);
    send_msg();
    add_tag(29'd1, WT_VARINT, 0);
    send_msg();
    add_tag(29'd1, WT_VARINT, 0);
    put_raw(8'h80, 1);
    send_msg();
    add_tag(29'd1, WT_FIXED32, 0);
    put_noise(2);
    send_msg();
    add_tag(29'd1, WT_LEN, 0);
    put_varint(64'd4, 0);
    put_noise(1);
    send_msg();
    add_tag(29'd1, WT_LEN, 0);
    put_varint(64'd2, 0);
    send_msg();
    add_tag(29'd1, WT_LEN, 0);
    put_raw(8'h80, 1);
    send_msg();
    add_tag(29'd1, WT_LEN, 0);
    put_varint(64'h7_FFFF_FFFF, 0);
    put_noise(5);
    send_msg();
    put_raw(8'h00, 1);
    send_msg();

    rand_bytes = byte_q.size();
    while (rand_bytes < 450) begin
      sel = $urandom_range(0, 9);
      repeat ($urandom_range(1, 4)) add_random_field();
      if (sel == 0) begin
        keep = $urandom_range(1, msg_bytes.size());
        while (msg_bytes.size() > keep) void'(msg_bytes.pop_back());
      end else if (sel == 1) begin
        msg_bytes[$urandom_range(0, msg_bytes.size() - 1)] = 8'($urandom);
      end else if (sel == 2) begin
        msg_bytes.delete();
        put_noise($urandom_range(1, 8));
      end
      rand_bytes += msg_bytes.size();
      send_msg();
    end

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    while (byte_q.size() != 0 || record_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_cnt == 0) $display("tb_protobuf_wire_field_tokenizer: clean");
    else $display("tb_protobuf_wire_field_tokenizer: errors");
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("tb_protobuf_wire_field_tokenizer: errors");
    $finish;
  end

endmodule

### filelist.f
rtl/pwft_pkg.sv
rtl/pwft_if.sv
rtl/pwft_in_reg.sv
rtl/pwft_parser.sv
rtl/pwft_out_reg.sv
rtl/protobuf_wire_field_tokenizer.sv
rtl/pwft_checker.sv
tb/tb_protobuf_wire_field_tokenizer.sv
